// ===== rtl/euler_zyx_to_rotation_matrix_defines.svh =====
// Assertion macros shared by the checker.
`ifndef EULER_ZYX_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ZYX_TO_ROTATION_MATRIX_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define EZ_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define EZ_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ===== rtl/ezr_pkg.sv =====
package ezr_pkg;
  localparam int AngleBits   = 16;
  localparam int OutFracBits = 14;
  localparam int FieldW      = 16;
  localparam int CordicN     = 30;
  localparam int CW          = 34;   // CORDIC datapath width, Q2.30 plus guard
  localparam int PW          = 36;   // product/sum width
  localparam int OutShift    = 30 - OutFracBits;
  localparam logic signed [CW-1:0] CordicGain = CW'(652032874);

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    logic signed [FieldW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  } mat_t;

  typedef struct packed {
    logic signed [FieldW-1:0] yaw_angle, pitch_angle, roll_angle;
  } ang_t;

  function automatic logic signed [31:0] atan_at(input int i);
    unique case (i)
      0: atan_at = 32'sd536870912;  1: atan_at = 32'sd316933406;
      2: atan_at = 32'sd167458907;  3: atan_at = 32'sd85004756;
      4: atan_at = 32'sd42667331;   5: atan_at = 32'sd21354465;
      6: atan_at = 32'sd10679838;   7: atan_at = 32'sd5340245;
      8: atan_at = 32'sd2670163;    9: atan_at = 32'sd1335087;
      10: atan_at = 32'sd667544;    11: atan_at = 32'sd333772;
      12: atan_at = 32'sd166886;    13: atan_at = 32'sd83443;
      14: atan_at = 32'sd41722;     15: atan_at = 32'sd20861;
      16: atan_at = 32'sd10430;     17: atan_at = 32'sd5215;
      18: atan_at = 32'sd2608;      19: atan_at = 32'sd1304;
      20: atan_at = 32'sd652;       21: atan_at = 32'sd326;
      22: atan_at = 32'sd163;       23: atan_at = 32'sd81;
      24: atan_at = 32'sd41;        25: atan_at = 32'sd20;
      26: atan_at = 32'sd10;        27: atan_at = 32'sd5;
      28: atan_at = 32'sd3;         default: atan_at = 32'sd1;
    endcase
  endfunction

  // Q2.30 product, round half up.
  function automatic logic signed [PW-1:0] qmul(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b);
    logic signed [2*PW-1:0] p;
    p = a * b + (2*PW)'(64'sd536870912);
    qmul = PW'(p >>> 30);
  endfunction

  function automatic logic [FieldW-1:0] to_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] one;
    one = PW'(1) <<< OutFracBits;
    r = (v + $signed(PW'((64'd1 << OutShift) >> 1))) >>> OutShift;
    if (r > one) r = one;
    if (r < -one) r = -one;
    to_out = r[FieldW-1:0];
  endfunction
endpackage

// ===== rtl/ezr_if.sv =====
interface ezr_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/euler_zyx_to_rotation_matrix.sv =====
// Z-Y-X Euler angles to rotation matrix.
// Channels: in_ch (sink) carries yaw_angle, pitch_angle, roll_angle in
// binary angle units; out_ch (source) carries r00..r22 in Q1.14.
// A transaction moves on a clock edge with valid and ready both high.
// Throughput: one transaction per cycle, no gaps, while out_ch is not stalled.
// Pipeline stages: 1 quadrant split, 30 CORDIC steps, 1 quadrant
// fixup, 2 product stages, 1 sum/saturate stage that is the output
// register.
// The whole pipeline advances together under one enable: it moves
// when the output register is empty or being taken. A stall freezes
// every stage in place, so nothing is lost or repeated; in_ch.ready
// drops in the same cycle as the stall.
// Reset (rst, synchronous) clears all valid bits; data registers are
// not reset. No state is kept between transactions.
module euler_zyx_to_rotation_matrix (
  input  logic clk,
  input  logic rst,
  ezr_if.sink   in_ch,
  ezr_if.source out_ch
);
  import ezr_pkg::*;

  logic  en;
  logic  cv, p1v, p2v;
  cval_t c [3];
  cval_t s [3];
  // products: first level
  logic signed [PW-1:0] czcy, czsy, czcx, szsy, cxsz, szsx, cysz, cysx, cycx,
                        czsx, cxcz, cxsz2, nsy, sxk, syk;
  logic signed [PW-1:0] t01a, t01b, t02a, t02b, t11a, t11b, t12a, t12b,
                        q00, q10, q20, q21, q22;
  ang_t a;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign a = in_ch.data;

  ezr_cordic u_cordic (
    .clk, .rst, .en,
    .in_valid (in_ch.valid),
    .angles   ({a.yaw_angle, a.pitch_angle, a.roll_angle}),
    .out_valid(cv),
    .cosv     (c),
    .sinv     (s)
  );

  // Lane 0 = yaw (z), 1 = pitch (y), 2 = roll (x).
  always_ff @(posedge clk) begin
    if (en) begin
      czcy  <= qmul(PW'(c[0]), PW'(c[1]));
      czsy  <= qmul(PW'(c[0]), PW'(s[1]));
      czcx  <= qmul(PW'(c[0]), PW'(c[2]));
      szsy  <= qmul(PW'(s[0]), PW'(s[1]));
      cxsz  <= qmul(PW'(c[2]), PW'(s[0]));
      szsx  <= qmul(PW'(s[0]), PW'(s[2]));
      cysz  <= qmul(PW'(c[1]), PW'(s[0]));
      cysx  <= qmul(PW'(c[1]), PW'(s[2]));
      cycx  <= qmul(PW'(c[1]), PW'(c[2]));
      czsx  <= qmul(PW'(c[0]), PW'(s[2]));
      cxcz  <= qmul(PW'(c[0]), PW'(c[2]));
      cxsz2 <= qmul(PW'(c[2]), PW'(s[0]));
      nsy   <= -PW'(s[1]);
      sxk   <= PW'(s[2]);
      syk   <= PW'(s[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t01a <= qmul(czsy, sxk);  t01b <= cxsz;
      t02a <= szsx;             t02b <= qmul(czcx, syk);
      t11a <= cxcz;             t11b <= qmul(szsy, sxk);
      t12a <= qmul(cxsz2, syk); t12b <= czsx;
      q00 <= czcy; q10 <= cysz; q20 <= nsy; q21 <= cysx; q22 <= cycx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0; p2v <= 1'b0; out_ch.valid <= 1'b0;
    end else if (en) begin
      p1v <= cv; p2v <= p1v; out_ch.valid <= p2v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.data.r00 <= to_out(q00);
      out_ch.data.r01 <= to_out(t01a - t01b);
      out_ch.data.r02 <= to_out(t02a + t02b);
      out_ch.data.r10 <= to_out(q10);
      out_ch.data.r11 <= to_out(t11a + t11b);
      out_ch.data.r12 <= to_out(t12a - t12b);
      out_ch.data.r20 <= to_out(q20);
      out_ch.data.r21 <= to_out(q21);
      out_ch.data.r22 <= to_out(q22);
    end
  end
endmodule

// ===== rtl/ezr_cordic.sv =====
// Three-lane pipelined CORDIC: a quadrant-split stage, one stage per
// rotation step, and a quadrant-fixup stage. Pipeline enable comes from the top level.
module ezr_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [47:0]     angles,
  output logic            out_valid,
  output ezr_pkg::cval_t  cosv [3],
  output ezr_pkg::cval_t  sinv [3]
);
  import ezr_pkg::*;

  cval_t              xs [CordicN+1][3];
  cval_t              ys [CordicN+1][3];
  logic signed [31:0] zs [CordicN+1][3];
  logic [1:0]         qs [CordicN+1][3];
  logic [CordicN:0]   vs;

  // Stage 0 input: quadrant split.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [31:0] a32, aq;
    assign a32 = 32'({{16{angles[16*(2-l)+15]}}, angles[16*(2-l) +: 16]}
                     << (32 - AngleBits));
    assign aq  = a32 + 32'h2000_0000;
    always_ff @(posedge clk) begin
      if (en) begin
        xs[0][l] <= CordicGain;
        ys[0][l] <= '0;
        qs[0][l] <= aq[31:30];
        zs[0][l] <= $signed(a32 - {aq[31:30], 30'd0});
      end
    end
    for (genvar i = 0; i < CordicN; i++) begin : g_stage
      always_ff @(posedge clk) begin
        if (en) begin
          if (!zs[i][l][31]) begin
            xs[i+1][l] <= xs[i][l] - (ys[i][l] >>> i);
            ys[i+1][l] <= ys[i][l] + (xs[i][l] >>> i);
            zs[i+1][l] <= zs[i][l] - atan_at(i);
          end else begin
            xs[i+1][l] <= xs[i][l] + (ys[i][l] >>> i);
            ys[i+1][l] <= ys[i][l] - (xs[i][l] >>> i);
            zs[i+1][l] <= zs[i][l] + atan_at(i);
          end
          qs[i+1][l] <= qs[i][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        unique case (qs[CordicN][l])
          2'd0: begin cosv[l] <= xs[CordicN][l];  sinv[l] <= ys[CordicN][l];  end
          2'd1: begin cosv[l] <= -ys[CordicN][l]; sinv[l] <= xs[CordicN][l];  end
          2'd2: begin cosv[l] <= -xs[CordicN][l]; sinv[l] <= -ys[CordicN][l]; end
          default: begin cosv[l] <= ys[CordicN][l]; sinv[l] <= -xs[CordicN][l]; end
        endcase
      end
    end
  end

  for (genvar i = 0; i < CordicN; i++) begin : g_v
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else if (en) vs[i+1] <= vs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vs[CordicN];
  end
endmodule

// ===== rtl/ezr_checker.sv =====
`include "euler_zyx_to_rotation_matrix_defines.svh"
module ezr_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ezr_pkg::mat_t  out_data
);
  import ezr_pkg::*;
  localparam logic signed [FieldW-1:0] One = FieldW'(1 << OutFracBits);

  `EZ_ASSERT_IMPL(a_ready_follows_out, clk, rst, !out_valid || out_ready, in_ready)
  `EZ_ASSERT_IMPL(a_stall_blocks_in, clk, rst, out_valid && !out_ready, !in_ready)
  `EZ_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `EZ_ASSERT_IMPL(a_r20_range, clk, rst, out_valid, out_data.r20 <= One && out_data.r20 >= -One)
endmodule

bind euler_zyx_to_rotation_matrix ezr_checker u_ezr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data)
);
